// ===== hdl/bcc_pkg.sv =====
// ---------------------------------------------------------------------------
// bcc_pkg
// Shared types, register codes and constants for the balance controller.
// ---------------------------------------------------------------------------
package bcc_pkg;

   typedef enum logic [2:0] {
      REG_ANGLE_SETPOINT = 3'd0,
      REG_UPRIGHT_GAIN_P = 3'd1,
      REG_UPRIGHT_GAIN_D = 3'd2,
      REG_SPEED_GAIN_P   = 3'd3,
      REG_SPEED_GAIN_I   = 3'd4,
      REG_TILT_LIMIT     = 3'd5,
      REG_PWM_PERIOD     = 3'd6,
      REG_SPEED_INTERVAL = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic signed [9:0] angle_setpoint;
      logic [19:0]       upright_gain_p;
      logic [19:0]       upright_gain_d;
      logic [19:0]       speed_gain_p;
      logic [19:0]       speed_gain_i;
      logic [7:0]        tilt_limit;
      logic [14:0]       pwm_period;
      logic [7:0]        speed_interval;
   } cfg_type;

   // word handed from the front stage to the mixing stage
   typedef struct packed {
      logic signed [15:0] upright;
      logic               fire;
      logic signed [27:0] smoothed;
      logic signed [23:0] integral;
      logic signed [15:0] turn;
      logic               stop;
   } mid_type;

   localparam logic signed [9:0]  RST_ANGLE_SETPOINT = 10'sd90;
   localparam logic [19:0]        RST_UPRIGHT_GAIN_P = 20'd345600;
   localparam logic [19:0]        RST_UPRIGHT_GAIN_D = 20'd870;
   localparam logic [19:0]        RST_SPEED_GAIN_P   = 20'd11520;
   localparam logic [19:0]        RST_SPEED_GAIN_I   = 20'd58;
   localparam logic [7:0]         RST_TILT_LIMIT     = 8'd40;
   localparam logic [14:0]        RST_PWM_PERIOD     = 15'd10000;
   localparam logic [7:0]         RST_SPEED_INTERVAL = 8'd4;

   localparam logic signed [16:0] UPRIGHT_ANGLE  = 17'sd90;
   localparam logic signed [28:0] INTEGRAL_LIMIT = 29'sd2560000;
   // ceil(2^33 / 3): exact quotient for any 32-bit dividend after >> 33
   localparam logic [31:0]        DIV3_MAGIC     = 32'hAAAA_AAAB;
   localparam int                 DIV3_SHIFT     = 33;

   function automatic logic signed [15:0] sat16(input logic signed [49:0] v);
      logic signed [15:0] r;
      if (v > 50'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -50'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

// ===== hdl/bcc_front.sv =====
// ---------------------------------------------------------------------------
// bcc_front
// Upright PD term, tilt guard and speed error smoothing / integral state.
// ---------------------------------------------------------------------------
module bcc_front
   import bcc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               advance,
   input  logic signed [15:0] angle,
   input  logic signed [15:0] gyro_rate,
   input  logic signed [15:0] left_speed,
   input  logic signed [15:0] right_speed,
   input  logic signed [15:0] speed_target,
   input  logic signed [15:0] turn_offset,
   output mid_type            front
);

   logic [7:0]         tick_ff, tick_in;
   logic signed [27:0] prev_ff;
   logic signed [23:0] integral_ff, integral_in;

   logic signed [20:0] kp, kd;
   logic signed [16:0] angle_err;
   logic signed [37:0] p_term;
   logic signed [36:0] d_term;
   logic signed [38:0] upright_sum, upright_bias;
   logic signed [30:0] upright_q;

   logic               fire;
   logic signed [17:0] spd_sum;
   logic signed [29:0] err_x;
   logic               err_neg;
   logic [28:0]        err_mag;
   logic [63:0]        div_prod;
   logic [27:0]        quo;
   logic signed [27:0] smoothed;
   logic signed [28:0] integ_sum;
   logic signed [23:0] integ_clamped;

   logic signed [16:0] dev;
   logic [16:0]        dev_mag;
   logic               stop;

   // upright PD, truncated toward zero
   always_comb begin
      kp           = $signed({1'b0, cfg.upright_gain_p});
      kd           = $signed({1'b0, cfg.upright_gain_d});
      angle_err    = 17'(cfg.angle_setpoint) - 17'(angle);
      p_term       = kp * angle_err;
      d_term       = kd * gyro_rate;
      upright_sum  = 39'(p_term) + 39'(d_term);
      upright_bias = upright_sum + (upright_sum[38] ? 39'sd255 : 39'sd0);
      upright_q    = 31'(upright_bias >>> 8);
   end

   // speed error, (e + 2*prev) / 3 by reciprocal on the magnitude
   always_comb begin
      tick_in  = tick_ff + 8'd1;
      fire     = (tick_in == cfg.speed_interval);
      spd_sum  = 18'(left_speed) + 18'(right_speed) - 18'(speed_target);
      err_x    = (30'(spd_sum) <<< 8) + (30'(prev_ff) <<< 1);
      err_neg  = err_x[29];
      err_mag  = err_neg ? 29'(-err_x) : 29'(err_x);
      div_prod = 64'({3'b000, err_mag}) * 64'(DIV3_MAGIC);
      quo      = div_prod[DIV3_SHIFT +: 28];
      smoothed = err_neg ? -$signed(quo) : $signed(quo);
      integ_sum = 29'(integral_ff) + 29'(smoothed);
      if (integ_sum > INTEGRAL_LIMIT) begin
         integ_clamped = 24'(INTEGRAL_LIMIT);
      end else if (integ_sum < -INTEGRAL_LIMIT) begin
         integ_clamped = 24'(-INTEGRAL_LIMIT);
      end else begin
         integ_clamped = integ_sum[23:0];
      end
   end

   always_comb begin
      dev     = angle - UPRIGHT_ANGLE;
      dev_mag = dev[16] ? 17'(-dev) : 17'(dev);
      stop    = dev_mag > {9'd0, cfg.tilt_limit};
      if (stop) begin
         integral_in = '0;
      end else if (fire) begin
         integral_in = integ_clamped;
      end else begin
         integral_in = integral_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff     <= '0;
         prev_ff     <= '0;
         integral_ff <= '0;
      end else if (advance) begin
         tick_ff     <= fire ? 8'd0 : tick_in;
         integral_ff <= integral_in;
         if (fire) begin
            prev_ff <= smoothed;
         end
      end
   end

   always_comb begin
      front.upright  = sat16(50'(upright_q));
      front.fire     = fire;
      front.smoothed = smoothed;
      front.integral = integ_clamped;
      front.turn     = turn_offset;
      front.stop     = stop;
   end

endmodule

// ===== hdl/bcc_mix.sv =====
// ---------------------------------------------------------------------------
// bcc_mix
// Speed PI term, total drive and left/right turn split with tilt cutoff.
// ---------------------------------------------------------------------------
module bcc_mix
   import bcc_pkg::*;
(
   input  cfg_type            cfg,
   input  mid_type            mid,
   output logic signed [17:0] left_drive,
   output logic signed [17:0] right_drive
);

   logic signed [20:0] ks, ki;
   logic signed [27:0] smoothed;
   logic signed [23:0] integral;
   logic signed [15:0] upright, turn, speed, total;
   logic signed [48:0] sp_term;
   logic signed [44:0] si_term;
   logic signed [49:0] speed_sum, speed_bias;
   logic signed [33:0] speed_q;
   logic signed [16:0] total_sp;

   always_comb begin
      ks         = $signed({1'b0, cfg.speed_gain_p});
      ki         = $signed({1'b0, cfg.speed_gain_i});
      smoothed   = $signed(mid.smoothed);
      integral   = $signed(mid.integral);
      upright    = $signed(mid.upright);
      turn       = $signed(mid.turn);
      sp_term    = ks * smoothed;
      si_term    = ki * integral;
      speed_sum  = 50'(sp_term) + 50'(si_term);
      speed_bias = speed_sum + (speed_sum[49] ? 50'sd65535 : 50'sd0);
      speed_q    = 34'(speed_bias >>> 16);
      speed      = sat16(50'(speed_q));
      total_sp   = 17'(upright) + 17'(speed);
      total      = mid.fire ? sat16(50'(total_sp)) : upright;
      if (mid.stop) begin
         left_drive  = '0;
         right_drive = '0;
      end else begin
         left_drive  = 18'(total) - 18'(turn);
         right_drive = 18'(total) + 18'(turn);
      end
   end

endmodule

// ===== hdl/bcc_drive.sv =====
// ---------------------------------------------------------------------------
// bcc_drive
// Clamps one drive to the PWM period, splits it into direction and duty.
// ---------------------------------------------------------------------------
module bcc_drive (
   input  logic signed [17:0] drive,
   input  logic [14:0]        pwm_period,
   output logic [14:0]        duty,
   output logic               forward
);

   logic signed [17:0] lim, clamped, mag;

   always_comb begin
      lim     = $signed({3'b000, pwm_period});
      forward = !drive[17] && (drive != 18'sd0);
      if (drive > lim) begin
         clamped = lim;
      end else if (drive < -lim) begin
         clamped = -lim;
      end else begin
         clamped = drive;
      end
      mag  = clamped[17] ? -clamped : clamped;
      duty = mag[14:0];
   end

endmodule

// ===== hdl/balance_cascade_controller.sv =====
// ---------------------------------------------------------------------------
// balance_cascade_controller
// Cascaded upright PD / speed PI controller for a two-wheel balancing robot.
// ---------------------------------------------------------------------------
// One request word per control tick carries angle, gyro rate, both wheel
// speeds, speed target and turn offset; one response word comes back with
// both duties, direction bits and the tilt stop flag.
// Both channels are valid/ready. The block is a three-register pipeline:
// input register, front register (upright term, speed state update) and
// response register. An accepted word passes the three registers in turn
// before it shows on rsp_valid; one word can be accepted every cycle while
// rsp_ready is high. The speed error state allows this: smoothing (divide
// by three) and the integral update close their loop through the front
// state registers. A stage holds its word while the next is full and cannot
// load, so a stalled receiver only backs up the pipeline once all are full.
// Synchronous reset empties the pipeline, clears tick count, smoothed error
// and integral, and loads the CSR defaults. CSR writes (csr_write_enable,
// csr_index, csr_write_data) take effect at once and belong in idle time.
// ---------------------------------------------------------------------------
module balance_cascade_controller
   import bcc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_angle,
   input  logic signed [15:0] req_gyro_rate,
   input  logic signed [15:0] req_left_speed,
   input  logic signed [15:0] req_right_speed,
   input  logic signed [15:0] req_speed_target,
   input  logic signed [15:0] req_turn_offset,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [14:0]        rsp_left_duty,
   output logic               rsp_left_forward,
   output logic [14:0]        rsp_right_duty,
   output logic               rsp_right_forward,
   output logic               rsp_tilt_stop,

   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [19:0]        csr_write_data
);

   cfg_type cfg_ff;

   logic               v1_ff, v2_ff, v3_ff;
   logic               ld1, ld2, ld3;
   logic signed [15:0] angle_ff, gyro_ff, lspd_ff, rspd_ff, target_ff, turn_ff;
   mid_type            front;
   mid_type            mid_ff;
   logic signed [17:0] left_drive, right_drive;
   logic [14:0]        left_duty, right_duty;
   logic               left_fwd, right_fwd;
   logic [14:0]        left_duty_ff, right_duty_ff;
   logic               left_fwd_ff, right_fwd_ff, stop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.angle_setpoint <= RST_ANGLE_SETPOINT;
         cfg_ff.upright_gain_p <= RST_UPRIGHT_GAIN_P;
         cfg_ff.upright_gain_d <= RST_UPRIGHT_GAIN_D;
         cfg_ff.speed_gain_p   <= RST_SPEED_GAIN_P;
         cfg_ff.speed_gain_i   <= RST_SPEED_GAIN_I;
         cfg_ff.tilt_limit     <= RST_TILT_LIMIT;
         cfg_ff.pwm_period     <= RST_PWM_PERIOD;
         cfg_ff.speed_interval <= RST_SPEED_INTERVAL;
      end else if (csr_write_enable) begin
         case (reg_index_type'(csr_index))
            REG_ANGLE_SETPOINT: cfg_ff.angle_setpoint <= csr_write_data[9:0];
            REG_UPRIGHT_GAIN_P: cfg_ff.upright_gain_p <= csr_write_data;
            REG_UPRIGHT_GAIN_D: cfg_ff.upright_gain_d <= csr_write_data;
            REG_SPEED_GAIN_P:   cfg_ff.speed_gain_p   <= csr_write_data;
            REG_SPEED_GAIN_I:   cfg_ff.speed_gain_i   <= csr_write_data;
            REG_TILT_LIMIT:     cfg_ff.tilt_limit     <= csr_write_data[7:0];
            REG_PWM_PERIOD:     cfg_ff.pwm_period     <= csr_write_data[14:0];
            REG_SPEED_INTERVAL: cfg_ff.speed_interval <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   // per-stage load enables; bubbles collapse
   assign ld3       = !v3_ff || rsp_ready;
   assign ld2       = !v2_ff || ld3;
   assign ld1       = !v1_ff || ld2;
   assign req_ready = ld1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (ld1) v1_ff <= req_valid;
         if (ld2) v2_ff <= v1_ff;
         if (ld3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld1 && req_valid) begin
         angle_ff  <= req_angle;
         gyro_ff   <= req_gyro_rate;
         lspd_ff   <= req_left_speed;
         rspd_ff   <= req_right_speed;
         target_ff <= req_speed_target;
         turn_ff   <= req_turn_offset;
      end
      if (ld2 && v1_ff) begin
         mid_ff <= front;
      end
      if (ld3 && v2_ff) begin
         left_duty_ff  <= left_duty;
         left_fwd_ff   <= left_fwd;
         right_duty_ff <= right_duty;
         right_fwd_ff  <= right_fwd;
         stop_ff       <= mid_ff.stop;
      end
   end

   bcc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .advance      (v1_ff && ld2),
      .angle        (angle_ff),
      .gyro_rate    (gyro_ff),
      .left_speed   (lspd_ff),
      .right_speed  (rspd_ff),
      .speed_target (target_ff),
      .turn_offset  (turn_ff),
      .front        (front)
   );

   bcc_mix u_mix (
      .cfg         (cfg_ff),
      .mid         (mid_ff),
      .left_drive  (left_drive),
      .right_drive (right_drive)
   );

   bcc_drive u_left (
      .drive      (left_drive),
      .pwm_period (cfg_ff.pwm_period),
      .duty       (left_duty),
      .forward    (left_fwd)
   );

   bcc_drive u_right (
      .drive      (right_drive),
      .pwm_period (cfg_ff.pwm_period),
      .duty       (right_duty),
      .forward    (right_fwd)
   );

   assign rsp_valid         = v3_ff;
   assign rsp_left_duty     = left_duty_ff;
   assign rsp_left_forward  = left_fwd_ff;
   assign rsp_right_duty    = right_duty_ff;
   assign rsp_right_forward = right_fwd_ff;
   assign rsp_tilt_stop     = stop_ff;

endmodule
